// ===== rtl/dns_a_record_response_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// DNS A-record parser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DNS_A_RECORD_RESPONSE_PARSER_TOP_MACROS_SVH
`define DNS_A_RECORD_RESPONSE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define DNSARP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsarp: same-cycle check failed");

// next-cycle implication
`define DNSARP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsarp: next-cycle check failed");

`endif

// ===== rtl/dnsarp_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS A-record parser package
// Payload types, configuration indexes and protocol constants.
// ----------------------------------------------------------------------------
package dnsarp_pkg;

    localparam int MAX_DATAGRAM = 512;
    localparam int POS_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int HEADER_BYTES = 12;
    localparam int FIXED_BYTES  = 10;

    localparam logic [15:0] FLAGS_MASK   = 16'hFB0F;
    localparam logic [15:0] FLAGS_EXPECT = 16'h8100;
    localparam logic [1:0]  LABEL_PTR    = 2'b11;
    localparam logic [1:0]  LABEL_LEN    = 2'b00;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUESTION_BYTES = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t data;
    } res_t;

endpackage

// ===== rtl/dnsarp_parse.sv =====
// ----------------------------------------------------------------------------
// DNS A-record parser byte engine
// Per-byte header check, question skip and answer walk; at most one verdict per datagram.
// ----------------------------------------------------------------------------
module dnsarp_parse (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dnsarp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dnsarp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                take,
    input  dnsarp_pkg::req_t                    req,
    output dnsarp_pkg::res_t                    res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QUESTION,
        PH_NAME,
        PH_LABEL,
        PH_POINTER,
        PH_FIXED,
        PH_RDATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OC_PENDING,
        OC_FOUND,
        OC_FAILED,
        OC_IGNORED
    } outcome_t;

    localparam int PW = dnsarp_pkg::POS_W;

    logic [15:0]   exp_id_reg,  exp_id_next;
    logic [8:0]    qbytes_reg,  qbytes_next;
    logic          armed_reg,   armed_next;
    logic [PW-1:0] pos_reg,     pos_next;
    phase_t        phase_reg,   phase_next;
    logic [7:0]    prev_reg,    prev_next;
    logic [15:0]   ans_reg,     ans_next;
    logic [15:0]   skip_reg,    skip_next;
    logic          type_a_reg,  type_a_next;
    logic          class_in_reg, class_in_next;
    logic [15:0]   dlen_reg,    dlen_next;
    logic [31:0]   addr_reg,    addr_next;
    outcome_t      outcome_reg, outcome_next;

    logic [7:0]  b;
    logic [15:0] w;
    logic [15:0] ans_dec;
    logic        found_w;

    assign b       = req.data_byte;
    assign w       = {prev_reg, b};
    assign ans_dec = ans_reg - 16'd1;

    always_comb
    begin
        exp_id_next   = exp_id_reg;
        qbytes_next   = qbytes_reg;
        armed_next    = armed_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        prev_next     = prev_reg;
        ans_next      = ans_reg;
        skip_next     = skip_reg;
        type_a_next   = type_a_reg;
        class_in_next = class_in_reg;
        dlen_next     = dlen_reg;
        addr_next     = addr_reg;
        outcome_next  = outcome_reg;
        found_w       = 1'b0;
        res.valid     = 1'b0;
        res.data      = '0;

        if (cfg_we)
        begin
            if (cfg_index == dnsarp_pkg::CFG_EXPECTED_ID)
            begin
                exp_id_next = cfg_data[15:0];
            end
            else if (cfg_index == dnsarp_pkg::CFG_QUESTION_BYTES)
            begin
                qbytes_next = cfg_data[8:0];
            end
        end

        if (take)
        begin
            if (req.req_type)
            begin
                armed_next    = 1'b1;
                pos_next      = '0;
                phase_next    = PH_HEADER;
                prev_next     = '0;
                ans_next      = '0;
                skip_next     = '0;
                type_a_next   = 1'b0;
                class_in_next = 1'b0;
                dlen_next     = '0;
                addr_next     = '0;
                outcome_next  = OC_PENDING;
            end
            else if (armed_reg)
            begin
                if (pos_reg < PW'(dnsarp_pkg::MAX_DATAGRAM))
                begin
                    pos_next  = pos_reg + PW'(1);
                    prev_next = b;
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (pos_reg == PW'(1))
                            begin
                                if (w != exp_id_reg)
                                begin
                                    outcome_next = OC_IGNORED;
                                end
                            end
                            else if (pos_reg == PW'(3))
                            begin
                                if (outcome_reg == OC_PENDING &&
                                    (w & dnsarp_pkg::FLAGS_MASK) != dnsarp_pkg::FLAGS_EXPECT)
                                begin
                                    outcome_next = OC_FAILED;
                                end
                            end
                            else if (pos_reg == PW'(5))
                            begin
                                if (outcome_reg == OC_PENDING && w != 16'd1)
                                begin
                                    outcome_next = OC_FAILED;
                                end
                            end
                            else if (pos_reg == PW'(7))
                            begin
                                ans_next = w;
                                if (outcome_reg == OC_PENDING && w == 16'd0)
                                begin
                                    outcome_next = OC_FAILED;
                                end
                            end
                            else if (pos_reg == PW'(dnsarp_pkg::HEADER_BYTES - 1))
                            begin
                                if (outcome_reg != OC_PENDING)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else if (qbytes_reg == 9'd0)
                                begin
                                    phase_next = PH_NAME;
                                end
                                else
                                begin
                                    skip_next  = 16'(qbytes_reg);
                                    phase_next = PH_QUESTION;
                                end
                            end
                        end
                        PH_QUESTION, PH_LABEL:
                        begin
                            skip_next = skip_reg - 16'd1;
                            if (skip_reg == 16'd1)
                            begin
                                phase_next = PH_NAME;
                            end
                        end
                        PH_NAME:
                        begin
                            if (b == 8'd0)
                            begin
                                skip_next  = '0;
                                phase_next = PH_FIXED;
                            end
                            else if (b[7:6] == dnsarp_pkg::LABEL_PTR)
                            begin
                                phase_next = PH_POINTER;
                            end
                            else if (b[7:6] == dnsarp_pkg::LABEL_LEN)
                            begin
                                skip_next  = 16'(b);
                                phase_next = PH_LABEL;
                            end
                            else
                            begin
                                outcome_next = OC_FAILED;
                                phase_next   = PH_DONE;
                            end
                        end
                        PH_POINTER:
                        begin
                            skip_next  = '0;
                            phase_next = PH_FIXED;
                        end
                        PH_FIXED:
                        begin
                            skip_next = skip_reg + 16'd1;
                            if (skip_reg == 16'd1)
                            begin
                                type_a_next = (w == 16'd1);
                            end
                            else if (skip_reg == 16'd3)
                            begin
                                class_in_next = (w == 16'd1);
                            end
                            else if (skip_reg == 16'(dnsarp_pkg::FIXED_BYTES - 1))
                            begin
                                dlen_next = w;
                                if (w == 16'd0)
                                begin
                                    ans_next = ans_dec;
                                    if (ans_dec == 16'd0)
                                    begin
                                        outcome_next = OC_FAILED;
                                        phase_next   = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_NAME;
                                    end
                                end
                                else
                                begin
                                    skip_next  = w;
                                    addr_next  = '0;
                                    phase_next = PH_RDATA;
                                end
                            end
                        end
                        PH_RDATA:
                        begin
                            addr_next = {addr_reg[23:0], b};
                            skip_next = skip_reg - 16'd1;
                            if (skip_reg == 16'd1)
                            begin
                                if (type_a_reg && class_in_reg && dlen_reg == 16'd4)
                                begin
                                    outcome_next = OC_FOUND;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    ans_next = ans_dec;
                                    if (ans_dec == 16'd0)
                                    begin
                                        outcome_next = OC_FAILED;
                                        phase_next   = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_NAME;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (req.last_byte)
                begin
                    if (pos_next >= PW'(dnsarp_pkg::HEADER_BYTES) &&
                        outcome_next != OC_IGNORED)
                    begin
                        found_w          = (outcome_next == OC_FOUND);
                        armed_next       = 1'b0;
                        res.valid        = 1'b1;
                        res.data.found   = found_w;
                        res.data.address = found_w ? addr_next : 32'd0;
                    end
                    pos_next      = '0;
                    phase_next    = PH_HEADER;
                    prev_next     = '0;
                    ans_next      = '0;
                    skip_next     = '0;
                    type_a_next   = 1'b0;
                    class_in_next = 1'b0;
                    dlen_next     = '0;
                    addr_next     = '0;
                    outcome_next  = OC_PENDING;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg   <= '0;
            qbytes_reg   <= 9'd5;
            armed_reg    <= 1'b0;
            pos_reg      <= '0;
            phase_reg    <= PH_HEADER;
            prev_reg     <= '0;
            ans_reg      <= '0;
            skip_reg     <= '0;
            type_a_reg   <= 1'b0;
            class_in_reg <= 1'b0;
            dlen_reg     <= '0;
            addr_reg     <= '0;
            outcome_reg  <= OC_PENDING;
        end
        else
        begin
            exp_id_reg   <= exp_id_next;
            qbytes_reg   <= qbytes_next;
            armed_reg    <= armed_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
            ans_reg      <= ans_next;
            skip_reg     <= skip_next;
            type_a_reg   <= type_a_next;
            class_in_reg <= class_in_next;
            dlen_reg     <= dlen_next;
            addr_reg     <= addr_next;
            outcome_reg  <= outcome_next;
        end
    end

`include "dns_a_record_response_parser_top_macros.svh"

    `DNSARP_ASSERT_IMP(a_res_needs_armed_byte, res.valid, take && armed_reg && !req.req_type)
    `DNSARP_ASSERT_NXT(a_res_disarms, res.valid, !armed_reg)
    `DNSARP_ASSERT_IMP(a_fail_zero_addr, res.valid && !res.data.found, res.data.address == 32'd0)
    `DNSARP_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= PW'(dnsarp_pkg::MAX_DATAGRAM))
    `DNSARP_ASSERT_NXT(a_arm_restarts, take && req.req_type, armed_reg && pos_reg == '0)

endmodule

// ===== rtl/dnsarp_out.sv =====
// ----------------------------------------------------------------------------
// DNS A-record parser result buffer
// Two-entry output register with skid slot between the engine and the response channel.
// ----------------------------------------------------------------------------
module dnsarp_out (
    input  logic             clk,
    input  logic             rst_n,
    input  dnsarp_pkg::res_t res,
    output logic             space,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output dnsarp_pkg::rsp_t rsp
);

    logic             v0_reg, v0_next;
    logic             v1_reg, v1_next;
    dnsarp_pkg::rsp_t d0_reg, d0_next;
    dnsarp_pkg::rsp_t d1_reg, d1_next;
    logic             pop;

    assign pop       = v0_reg && rsp_ready;
    assign space     = !v1_reg;
    assign rsp_valid = v0_reg;
    assign rsp       = d0_reg;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (pop)
        begin
            v0_next = v1_reg;
            d0_next = d1_reg;
            v1_next = 1'b0;
        end
        if (res.valid)
        begin
            if (!v0_next)
            begin
                v0_next = 1'b1;
                d0_next = res.data;
            end
            else
            begin
                v1_next = 1'b1;
                d1_next = res.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

endmodule

// ===== rtl/dns_a_record_response_parser_top.sv =====
// A datagram's verdict is registered in the result buffer when its final byte is taken.
// Throughput: one byte or arm request per cycle while the result buffer has space;
//   the parse engine updates all field state in a single pass per byte.
// The two-entry result buffer keeps req_ready high while one verdict waits.
// Reset: asynchronous, active low; disarmed, expected_id 0, question_bytes 5.
// ----------------------------------------------------------------------------
// DNS A-record response parser top level
// Parses a DNS response byte stream and reports the first A/IN address.
// ----------------------------------------------------------------------------
module dns_a_record_response_parser_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dnsarp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dnsarp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  dnsarp_pkg::req_t                    req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output dnsarp_pkg::rsp_t                    rsp
);

    dnsarp_pkg::res_t res;
    logic             space;

    assign req_ready = space;

    dnsarp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (req_valid && space),
        .req       (req),
        .res       (res)
    );

    dnsarp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== tb/tb_dns_a_record_response_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS A-record response parser testbench
// Streams armed and unarmed response datagrams into the parser, both
// well-formed and broken. The expected verdicts come from a byte-level
// predictor kept in step with every accepted transaction and every
// register write. Each delivered verdict is compared with the oldest one
// predicted, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_dns_a_record_response_parser_top;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QUESTION,
        PH_NAME,
        PH_LABEL,
        PH_POINTER,
        PH_FIXED,
        PH_RDATA,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        OUT_PENDING,
        OUT_FOUND,
        OUT_FAILED,
        OUT_IGNORED
    } outcome_t;

    typedef enum int {
        NAME_ROOT,
        NAME_PTR,
        NAME_LABELS,
        NAME_LABELS_PTR,
        NAME_BAD
    } name_form_t;

    localparam logic [15:0] RR_TYPE_A          = 16'd1;
    localparam logic [15:0] RR_TYPE_CNAME      = 16'd5;
    localparam logic [15:0] RR_TYPE_TXT        = 16'd16;
    localparam logic [15:0] RR_TYPE_AAAA       = 16'd28;
    localparam logic [15:0] RR_CLASS_IN        = 16'd1;
    localparam int          A_RDATA_BYTES      = 4;
    localparam logic [15:0] FLAGS_STD_RESPONSE = 16'h8180;
    localparam logic [15:0] FLAGS_SERVFAIL     = 16'h8182;
    localparam logic [15:0] FLAGS_QUERY        = 16'h0000;
    localparam int          HOLD_OFF_CYCLES    = 400;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [dnsarp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dnsarp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                              req_valid = 1'b0;
    logic                              req_ready;
    dnsarp_pkg::req_t                  req       = '0;
    logic                              rsp_valid;
    logic                              rsp_ready = 1'b0;
    dnsarp_pkg::rsp_t                  rsp;

    dnsarp_pkg::req_t pending_items[$];
    dnsarp_pkg::rsp_t expected_verdicts[$];
    logic [7:0]       datagram_bytes[$];
    dnsarp_pkg::rsp_t oldest_verdict;
    logic        req_fire = 1'b0;
    int          mismatch_count = 0;
    int          queued_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_epoch = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [15:0] cur_id = 16'd0;
    int          cur_qb = 5;

    // predictor state
    logic [15:0]  cfg_id;
    logic [8:0]   cfg_qbytes;
    logic         st_armed;
    logic [9:0]   st_pos;
    parse_phase_t st_phase;
    logic [7:0]   st_prev;
    logic [15:0]  st_answers;
    logic [15:0]  st_skip;
    logic [15:0]  st_rtype;
    logic [15:0]  st_rclass;
    logic [15:0]  st_rdlen;
    logic [31:0]  st_addr;
    outcome_t     st_outcome;

    dns_a_record_response_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR at %0t: %s: got %h, wanted %h", $time, what, got, want);
    endtask

    task automatic clear_datagram_state();
        st_pos     = '0;
        st_phase   = PH_HEADER;
        st_prev    = '0;
        st_answers = '0;
        st_skip    = '0;
        st_rtype   = '0;
        st_rclass  = '0;
        st_rdlen   = '0;
        st_addr    = '0;
        st_outcome = OUT_PENDING;
    endtask

    task automatic close_record();
        st_answers = st_answers - 16'd1;
        if (st_answers == 16'd0)
        begin
            st_outcome = OUT_FAILED;
            st_phase   = PH_DONE;
        end
        else
            st_phase = PH_NAME;
    endtask

    task automatic parse_dns_byte(input dnsarp_pkg::req_t item);
        logic [7:0]       b;
        logic [15:0]      word;
        logic [9:0]       counted;
        outcome_t         verdict;
        logic [31:0]      addr;
        dnsarp_pkg::rsp_t v;
        b = item.data_byte;
        if (item.req_type)
        begin
            clear_datagram_state();
            st_armed = 1'b1;
            return;
        end
        if (!st_armed)
            return;
        if (st_pos < dnsarp_pkg::MAX_DATAGRAM)
        begin
            word = {st_prev, b};
            case (st_phase)
                PH_HEADER:
                begin
                    case (st_pos)
                        10'd1:
                            if (word != cfg_id)
                                st_outcome = OUT_IGNORED;
                        10'd3:
                            if (st_outcome == OUT_PENDING
                                && (word & dnsarp_pkg::FLAGS_MASK) != dnsarp_pkg::FLAGS_EXPECT)
                                st_outcome = OUT_FAILED;
                        10'd5:
                            if (st_outcome == OUT_PENDING && word != 16'd1)
                                st_outcome = OUT_FAILED;
                        10'd7:
                        begin
                            st_answers = word;
                            if (st_outcome == OUT_PENDING && word == 16'd0)
                                st_outcome = OUT_FAILED;
                        end
                        10'd11:
                        begin
                            if (st_outcome != OUT_PENDING)
                                st_phase = PH_DONE;
                            else if (cfg_qbytes == 9'd0)
                                st_phase = PH_NAME;
                            else
                            begin
                                st_skip  = 16'(cfg_qbytes);
                                st_phase = PH_QUESTION;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_QUESTION, PH_LABEL:
                begin
                    st_skip = st_skip - 16'd1;
                    if (st_skip == 16'd0)
                        st_phase = PH_NAME;
                end
                PH_NAME:
                begin
                    if (b == 8'd0)
                    begin
                        st_skip  = '0;
                        st_phase = PH_FIXED;
                    end
                    else if (b[7:6] == dnsarp_pkg::LABEL_PTR)
                        st_phase = PH_POINTER;
                    else if (b[7:6] == dnsarp_pkg::LABEL_LEN)
                    begin
                        st_skip  = 16'(b);
                        st_phase = PH_LABEL;
                    end
                    else
                    begin
                        st_outcome = OUT_FAILED;
                        st_phase   = PH_DONE;
                    end
                end
                PH_POINTER:
                begin
                    st_skip  = '0;
                    st_phase = PH_FIXED;
                end
                PH_FIXED:
                begin
                    if (st_skip == 16'd1)
                        st_rtype = word;
                    else if (st_skip == 16'd3)
                        st_rclass = word;
                    else if (st_skip == 16'd9)
                        st_rdlen = word;
                    st_skip = st_skip + 16'd1;
                    if (st_skip == dnsarp_pkg::FIXED_BYTES)
                    begin
                        if (st_rdlen == 16'd0)
                            close_record();
                        else
                        begin
                            st_skip  = st_rdlen;
                            st_addr  = '0;
                            st_phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA:
                begin
                    st_addr = {st_addr[23:0], b};
                    st_skip = st_skip - 16'd1;
                    if (st_skip == 16'd0)
                    begin
                        if (st_rtype == RR_TYPE_A && st_rclass == RR_CLASS_IN
                            && st_rdlen == A_RDATA_BYTES)
                        begin
                            st_outcome = OUT_FOUND;
                            st_phase   = PH_DONE;
                        end
                        else
                            close_record();
                    end
                end
                default: ;
            endcase
            st_prev = b;
            st_pos  = st_pos + 10'd1;
        end
        if (!item.last_byte)
            return;
        counted = st_pos;
        verdict = st_outcome;
        addr    = st_addr;
        clear_datagram_state();
        if (counted < dnsarp_pkg::HEADER_BYTES || verdict == OUT_IGNORED)
            return;
        st_armed  = 1'b0;
        v.found   = (verdict == OUT_FOUND);
        v.address = v.found ? addr : 32'd0;
        expected_verdicts.push_back(v);
    endtask

    // monitor: check delivered verdicts, then track accepted transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("verdict with none pending", rsp.address, 32'd0);
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (rsp.found !== oldest_verdict.found)
                        report_mismatch("found", 32'(rsp.found), 32'(oldest_verdict.found));
                    if (rsp.address !== oldest_verdict.address)
                        report_mismatch("address", rsp.address, oldest_verdict.address);
                end
            end
            if (req_valid && req_ready)
                parse_dns_byte(req);
            if (cfg_we)
            begin
                if (cfg_index == dnsarp_pkg::CFG_EXPECTED_ID)
                    cfg_id = cfg_data;
                else if (cfg_index == dnsarp_pkg::CFG_QUESTION_BYTES)
                    cfg_qbytes = cfg_data[8:0];
            end
        end
        req_fire <= rst_n && req_valid && req_ready;
    end

    // driver: hold the transaction until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= pending_items.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver: random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_seen != hold_off_epoch)
        begin
            hold_seen <= hold_off_epoch;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic put16(input logic [15:0] v);
        datagram_bytes.push_back(v[15:8]);
        datagram_bytes.push_back(v[7:0]);
    endtask

    task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic add_question(input int n);
        repeat (n) datagram_bytes.push_back(8'($urandom));
    endtask

    task automatic add_trailer(input int n);
        repeat (n) datagram_bytes.push_back(8'($urandom));
    endtask

    task automatic add_record(input name_form_t form, input logic [15:0] rtype,
                              input logic [15:0] rclass, input int rdlen, input int fill);
        int n_labels;
        int len;
        case (form)
            NAME_ROOT:
                datagram_bytes.push_back(8'd0);
            NAME_PTR:
            begin
                datagram_bytes.push_back({dnsarp_pkg::LABEL_PTR, 6'($urandom)});
                datagram_bytes.push_back(8'($urandom));
            end
            NAME_LABELS, NAME_LABELS_PTR:
            begin
                n_labels = $urandom_range(1, 3);
                repeat (n_labels)
                begin
                    len = ($urandom_range(99) < 5) ? 63 : $urandom_range(1, 6);
                    datagram_bytes.push_back(8'(len));
                    add_question(len);
                end
                if (form == NAME_LABELS)
                    datagram_bytes.push_back(8'd0);
                else
                begin
                    datagram_bytes.push_back({dnsarp_pkg::LABEL_PTR, 6'($urandom)});
                    datagram_bytes.push_back(8'($urandom));
                end
            end
            default:
            begin
                datagram_bytes.push_back({($urandom_range(1) ? 2'b01 : 2'b10), 6'($urandom)});
                add_question(2);
            end
        endcase
        put16(rtype);
        put16(rclass);
        add_question(4);
        put16(16'(rdlen));
        repeat (rdlen)
            datagram_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    task automatic send_msg(input bit arm, input int keep);
        if (arm)
        begin
            pending_items.push_back(dnsarp_pkg::req_t'{1'b1, 8'($urandom), 1'($urandom)});
            queued_count++;
        end
        for (int i = 0; i < keep; i++)
        begin
            pending_items.push_back(dnsarp_pkg::req_t'{1'b0, datagram_bytes[i],
                                                       (i == keep - 1)});
            queued_count++;
        end
        datagram_bytes.delete();
    endtask

    task automatic queue_random_datagram();
        int          an;
        int          qlen;
        int          nrec;
        int          r;
        int          rdlen;
        int          keep;
        name_form_t  form;
        logic [15:0] id;
        logic [15:0] flags;
        logic [15:0] qd;
        logic [15:0] rtype;
        logic [15:0] rclass;
        if ($urandom_range(99) < 5)
        begin
            add_trailer($urandom_range(1, 40));
            send_msg($urandom_range(1), datagram_bytes.size());
            return;
        end
        id    = ($urandom_range(99) < 90) ? cur_id : 16'($urandom);
        flags = ($urandom_range(99) < 85)
                ? ((16'($urandom) & ~dnsarp_pkg::FLAGS_MASK) | dnsarp_pkg::FLAGS_EXPECT)
                : 16'($urandom);
        qd    = ($urandom_range(99) < 90) ? 16'd1 : 16'($urandom_range(0, 3));
        r     = $urandom_range(99);
        if (r < 85)
            an = $urandom_range(1, 3);
        else if (r < 90)
            an = 0;
        else
            an = $urandom_range(0, 65535);
        add_header(id, flags, qd, 16'(an));
        qlen = cur_qb;
        if ($urandom_range(99) < 5)
            qlen = cur_qb + $urandom_range(0, 6) - 3;
        if (qlen < 0)
            qlen = 0;
        add_question(qlen);
        nrec = (an >= 1 && an <= 3) ? an : $urandom_range(1, 3);
        repeat (nrec)
        begin
            r = $urandom_range(99);
            if (r < 10)
                form = NAME_ROOT;
            else if (r < 50)
                form = NAME_PTR;
            else if (r < 75)
                form = NAME_LABELS;
            else if (r < 95)
                form = NAME_LABELS_PTR;
            else
                form = NAME_BAD;
            r = $urandom_range(99);
            if (r < 45)
                rtype = RR_TYPE_A;
            else if (r < 60)
                rtype = RR_TYPE_CNAME;
            else if (r < 75)
                rtype = RR_TYPE_AAAA;
            else if (r < 85)
                rtype = RR_TYPE_TXT;
            else
                rtype = 16'($urandom);
            rclass = ($urandom_range(99) < 85) ? RR_CLASS_IN : 16'($urandom);
            if (rtype == RR_TYPE_A && rclass == RR_CLASS_IN && $urandom_range(99) < 85)
                rdlen = A_RDATA_BYTES;
            else if ($urandom_range(99) < 3)
                rdlen = $urandom_range(200, 300);
            else
                rdlen = $urandom_range(0, 8);
            add_record(form, rtype, rclass, rdlen, -1);
        end
        if ($urandom_range(99) < 30)
            add_trailer($urandom_range(1, 4));
        keep = datagram_bytes.size();
        if ($urandom_range(99) < 15)
            keep = $urandom_range(1, keep);
        send_msg($urandom_range(99) < 95, keep);
    endtask

    task automatic write_register(input logic [dnsarp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dnsarp_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] id, input int qb);
        cur_id = id;
        cur_qb = qb;
        write_register(dnsarp_pkg::CFG_EXPECTED_ID, id);
        write_register(dnsarp_pkg::CFG_QUESTION_BYTES, 16'(qb));
    endtask

    task automatic wait_drained();
        int guard;
        while (pending_items.size() != 0 || req_valid)
            @(posedge clk);
        guard = 0;
        while (expected_verdicts.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        queued_count = 0;
        while (queued_count < n_items)
            queue_random_datagram();
    endtask

    initial
    begin
        cfg_id     = 16'd0;
        cfg_qbytes = 9'd5;
        st_armed   = 1'b0;
        clear_datagram_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes while disarmed
        datagram_bytes.push_back(8'h00);
        datagram_bytes.push_back(8'hFF);
        send_msg(1'b0, 2);
        // short datagram keeps the lookup armed for the next one
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        send_msg(1'b1, 4);
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        add_question(cur_qb);
        add_record(NAME_PTR, RR_TYPE_A, RR_CLASS_IN, A_RDATA_BYTES, 255);
        send_msg(1'b0, datagram_bytes.size());
        // foreign ID, then a server failure on the same arming
        add_header(~cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        send_msg(1'b1, dnsarp_pkg::HEADER_BYTES);
        add_header(cur_id, FLAGS_SERVFAIL, 16'd1, 16'd1);
        send_msg(1'b0, dnsarp_pkg::HEADER_BYTES);
        // match on the second record, bytes after the match
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd2);
        add_question(cur_qb);
        add_record(NAME_LABELS, RR_TYPE_CNAME, RR_CLASS_IN, 3, -1);
        add_record(NAME_LABELS, RR_TYPE_A, RR_CLASS_IN, A_RDATA_BYTES, 0);
        add_trailer(3);
        send_msg(1'b1, datagram_bytes.size());
        // answers run out
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        add_question(cur_qb);
        add_record(NAME_ROOT, RR_TYPE_A, RR_CLASS_IN, 0, -1);
        add_trailer(2);
        send_msg(1'b1, datagram_bytes.size());
        // reserved label type
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        add_question(cur_qb);
        add_record(NAME_BAD, RR_TYPE_A, RR_CLASS_IN, A_RDATA_BYTES, -1);
        send_msg(1'b1, datagram_bytes.size());
        // two questions, then no answers
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd2, 16'd1);
        add_question(cur_qb);
        send_msg(1'b1, datagram_bytes.size());
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd0);
        add_question(cur_qb);
        send_msg(1'b1, datagram_bytes.size());
        // datagram ends inside the address
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd1);
        add_question(cur_qb);
        add_record(NAME_PTR, RR_TYPE_A, RR_CLASS_IN, A_RDATA_BYTES, -1);
        send_msg(1'b1, datagram_bytes.size() - 2);
        run_random(150);
        wait_drained();

        configure(16'hFFFF, 288);
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        // the match lies past the parsed window
        add_header(cur_id, FLAGS_STD_RESPONSE, 16'd1, 16'd2);
        add_question(cur_qb);
        add_record(NAME_PTR, RR_TYPE_TXT, RR_CLASS_IN, 300, -1);
        add_record(NAME_PTR, RR_TYPE_A, RR_CLASS_IN, A_RDATA_BYTES, -1);
        send_msg(1'b1, datagram_bytes.size());
        run_random(450);
        wait_drained();

        configure(16'($urandom), 0);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random(350);
        wait_drained();

        configure(16'h0000, 5);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_random(350);
        wait_drained();

        configure(16'($urandom), 12);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_epoch++;
        repeat (24)
        begin
            add_header(cur_id, FLAGS_QUERY, 16'd1, 16'd1);
            send_msg(1'b1, dnsarp_pkg::HEADER_BYTES);
        end
        wait_drained();

        configure(16'($urandom), $urandom_range(5, 40));
        run_random(300);
        wait_drained();

        if (expected_verdicts.size() != 0)
            report_mismatch("verdicts never delivered", 32'(expected_verdicts.size()), 32'd0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
